>>> hdl/iht_pkg.sv
// Shared types, constants and helpers for the identifier intern table.
package iht_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam int STR_INDEX_W = 10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM,
        ST_MOD,
        ST_REM,
        ST_BKT,
        ST_HEAD,
        ST_NODE,
        ST_NODEW,
        ST_RD,
        ST_CMP,
        ST_PUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic eq;
        logic term;
    } t_cmp;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c - CH_UPPER_A + CH_LOWER_A;
        end
        return c;
    endfunction

endpackage

>>> hdl/iht_cmp.sv
// Case-folding byte compare used in the compare step of the chain walk.
module iht_cmp (
    input  logic [7:0]    i_a,
    input  logic [7:0]    i_b,
    output iht_pkg::t_cmp o_res
);
    import iht_pkg::*;

    logic [7:0] w_fa;
    logic [7:0] w_fb;

    assign w_fa       = fold_case(i_a);
    assign w_fb       = fold_case(i_b);
    assign o_res.eq   = (w_fa == w_fb);
    assign o_res.term = (w_fa == CH_NUL);

endmodule

>>> hdl/identifier_intern_hash_table_core.sv
// Top level: case-insensitive identifier intern table with chained buckets.
//
//  channel | dir | signals                      | payload
//  s_axis  | in  | tvalid tready tdata tlast    | char_code, last_char
//  m_axis  | out | tvalid tready tdata tuser    | string_index, already_existed/overflow
//
// A byte without tlast is taken in the idle state. The final byte adds a terminator
// step (straight to done on store overflow), a reciprocal-multiply bucket reduction
// (quotient, then remainder), a bucket step, then for an occupied bucket a head step
// and a chain walk of a node read per node and a read and compare per character,
// then a push step on a new name and a done step, all on one byte-compare unit over the store's two read ports.
// Synchronous active-low reset; no clearing pass (bucket valid bits reset).
// The input stalls from the final byte until its result is in the output
// register; that register holds while m_axis_tready is low.
module identifier_intern_hash_table_core #(
    parameter int STRING_STORE_DEPTH = 1024,
    parameter int BUCKET_COUNT       = 64,
    parameter int MAX_NODES          = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
    input  logic        s_axis_tlast,  // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [9:0] string_index, [15:10] zero
    output logic [1:0]  m_axis_tuser   // [0] already_existed, [1] overflow
);
    import iht_pkg::*;

    localparam int SW = $clog2(STRING_STORE_DEPTH);
    localparam int NW = $clog2(MAX_NODES);
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int HW = SW + 8;
    localparam int EW = SW + NW + 1;
    localparam int RSH = HW + BW;
    localparam int RW = HW + 2;
    localparam int QW = HW - BW + 1;

    localparam logic [SW:0] SSD_L = (SW+1)'(STRING_STORE_DEPTH);
    localparam logic [NW:0] MAXN_L = (NW+1)'(MAX_NODES);
    localparam logic [BW:0] BC_L = (BW+1)'(BUCKET_COUNT);
    localparam logic [HW-1:0] BC_H = HW'(BUCKET_COUNT);
    // ceil(2^RSH / BUCKET_COUNT): exact quotient for every HW-bit sum
    localparam longint unsigned RECIP_I =
        ((64'd1 << RSH) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_I);

    // storage
    logic [7:0]    r_str_mem [STRING_STORE_DEPTH];
    logic [NW-1:0] r_head_mem [BUCKET_COUNT];
    logic [EW-1:0] r_node_mem [MAX_NODES];
    logic [BUCKET_COUNT-1:0] r_bkt_valid;

    t_state r_state, n_state;

    logic [SW:0]   r_wp, n_wp;
    logic [SW:0]   r_name, n_name;
    logic [NW:0]   r_ncnt, n_ncnt;
    logic [HW-1:0] r_hash, n_hash;
    logic          r_ovp, n_ovp;
    logic [QW-1:0] r_quo, n_quo;
    logic [BW-1:0] r_rem, n_rem;
    logic [BW-1:0] r_bkt, n_bkt;
    logic [NW-1:0] r_node, n_node;
    logic [SW-1:0] r_pa, n_pa;
    logic [SW-1:0] r_pb, n_pb;
    logic          r_res_exist, n_res_exist;
    logic          r_res_ovf, n_res_ovf;
    logic [SW-1:0] r_res_idx, n_res_idx;
    logic          r_rewind, n_rewind;

    logic          r_oval;
    logic [STR_INDEX_W-1:0] r_oidx;
    logic          r_oexist;
    logic          r_oovf;

    logic [7:0]    r_qa, r_qb;
    logic [NW-1:0] r_head_q;
    logic [EW-1:0] r_node_q;

    logic          w_in_xfer;
    logic          w_out_free;
    logic          w_str_we;
    logic [SW-1:0] w_str_wa;
    logic [7:0]    w_str_wd;
    logic          w_push;
    logic [HW+RW-1:0] w_prod;
    logic [QW-1:0] w_quo;
    logic [HW-1:0] w_quo_h;
    logic [HW-1:0] w_qb;
    logic [HW-1:0] w_diff;
    logic [BW:0]   w_bkt_inc;
    logic [BW-1:0] w_bkt_sel;
    t_cmp          w_cmp;

    logic [SW-1:0] w_q_start;
    logic [NW-1:0] w_q_link;
    logic          w_q_lv;

    assign w_q_start = r_node_q[EW-1 -: SW];
    assign w_q_link  = r_node_q[NW:1];
    assign w_q_lv    = r_node_q[0];

    iht_cmp u_cmp (
        .i_a   (r_qa),
        .i_b   (r_qb),
        .o_res (w_cmp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_oval || m_axis_tready;

    // bucket reduction: quotient by reciprocal multiply, then sum - quotient * count
    assign w_prod    = r_hash * RECIP;
    assign w_quo     = w_prod[RSH +: QW];
    assign w_quo_h   = HW'(r_quo);
    assign w_qb      = w_quo_h * BC_H;
    assign w_diff    = r_hash - w_qb;
    assign w_bkt_inc = {1'b0, r_rem} + (BW+1)'(1);
    assign w_bkt_sel = (w_bkt_inc == BC_L) ? '0 : w_bkt_inc[BW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_xfer && s_axis_tlast) n_state = ST_TERM;
            ST_TERM: begin
                if (r_ovp || r_wp >= SSD_L) n_state = ST_DONE;
                else                        n_state = ST_MOD;
            end
            ST_MOD:   n_state = ST_REM;
            ST_REM:   n_state = ST_BKT;
            ST_BKT:   n_state = r_bkt_valid[w_bkt_sel] ? ST_HEAD : ST_PUSH;
            ST_HEAD:  n_state = ST_NODE;
            ST_NODE:  n_state = ST_NODEW;
            ST_NODEW: n_state = ST_RD;
            ST_RD:    n_state = ST_CMP;
            ST_CMP: begin
                if (!w_cmp.eq)      n_state = w_q_lv ? ST_NODE : ST_PUSH;
                else if (w_cmp.term) n_state = ST_DONE;
                else                 n_state = ST_RD;
            end
            ST_PUSH:  n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_wp        = r_wp;
        n_name      = r_name;
        n_ncnt      = r_ncnt;
        n_hash      = r_hash;
        n_ovp       = r_ovp;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bkt       = r_bkt;
        n_node      = r_node;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_res_exist = r_res_exist;
        n_res_ovf   = r_res_ovf;
        n_res_idx   = r_res_idx;
        n_rewind    = r_rewind;
        w_str_we    = 1'b0;
        w_str_wa    = r_wp[SW-1:0];
        w_str_wd    = s_axis_tdata;
        w_push      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && s_axis_tdata != CH_NUL && !r_ovp) begin
                    if (r_wp >= SSD_L) begin
                        n_ovp = 1'b1;
                    end else begin
                        w_str_we = 1'b1;
                        n_wp     = r_wp + (SW+1)'(1);
                        n_hash   = r_hash + HW'(fold_case(s_axis_tdata));
                    end
                end
            end
            ST_TERM: begin
                if (r_ovp || r_wp >= SSD_L) begin
                    n_res_exist = 1'b0;
                    n_res_ovf   = 1'b1;
                    n_res_idx   = '0;
                    n_rewind    = 1'b1;
                end else begin
                    w_str_we = 1'b1;
                    w_str_wd = CH_NUL;
                    n_wp     = r_wp + (SW+1)'(1);
                end
            end
            ST_MOD:   n_quo = w_quo;
            ST_REM:   n_rem = w_diff[BW-1:0];
            ST_BKT:   n_bkt = w_bkt_sel;
            ST_HEAD:  n_node = r_head_q;
            ST_NODE:  ;
            ST_NODEW: begin
                n_pa = w_q_start;
                n_pb = r_name[SW-1:0];
            end
            ST_RD:    ;
            ST_CMP: begin
                if (!w_cmp.eq) begin
                    n_node = w_q_link;
                end else if (w_cmp.term) begin
                    n_res_exist = 1'b1;
                    n_res_ovf   = 1'b0;
                    n_res_idx   = w_q_start;
                    n_rewind    = 1'b1;
                end else begin
                    n_pa = r_pa + SW'(1);
                    n_pb = r_pb + SW'(1);
                end
            end
            ST_PUSH: begin
                if (r_ncnt >= MAXN_L) begin
                    n_res_exist = 1'b0;
                    n_res_ovf   = 1'b1;
                    n_res_idx   = '0;
                    n_rewind    = 1'b1;
                end else begin
                    w_push      = 1'b1;
                    n_ncnt      = r_ncnt + (NW+1)'(1);
                    n_res_exist = 1'b0;
                    n_res_ovf   = 1'b0;
                    n_res_idx   = r_name[SW-1:0];
                    n_rewind    = 1'b0;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_hash = '0;
                    n_ovp  = 1'b0;
                    if (r_rewind) begin
                        n_wp = r_name;
                    end else begin
                        // next name starts past this terminator
                        n_name = r_wp;
                    end
                end
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_str_we) begin
            r_str_mem[w_str_wa] <= w_str_wd;
        end
        if (r_state == ST_RD) begin
            r_qa <= r_str_mem[r_pa];
            r_qb <= r_str_mem[r_pb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_head_mem[r_bkt] <= r_ncnt[NW-1:0];
        end
        if (r_state == ST_BKT) begin
            r_head_q <= r_head_mem[w_bkt_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_node_mem[r_ncnt[NW-1:0]] <= {r_name[SW-1:0],
                                           r_bkt_valid[r_bkt] ? r_head_q : {NW{1'b0}},
                                           r_bkt_valid[r_bkt]};
        end
        if (r_state == ST_NODE) begin
            r_node_q <= r_node_mem[r_node];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_name      <= '0;
            r_ncnt      <= '0;
            r_hash      <= '0;
            r_ovp       <= 1'b0;
            r_bkt_valid <= '0;
            r_oval      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_name  <= n_name;
            r_ncnt  <= n_ncnt;
            r_hash  <= n_hash;
            r_ovp   <= n_ovp;
            if (w_push) begin
                r_bkt_valid[r_bkt] <= 1'b1;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_oval <= 1'b1;
            end else if (m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_bkt       <= n_bkt;
        r_node      <= n_node;
        r_pa        <= n_pa;
        r_pb        <= n_pb;
        r_res_exist <= n_res_exist;
        r_res_ovf   <= n_res_ovf;
        r_res_idx   <= n_res_idx;
        r_rewind    <= n_rewind;
        if (r_state == ST_DONE && w_out_free) begin
            r_oidx   <= STR_INDEX_W'(32'(r_res_idx));
            r_oexist <= r_res_exist;
            r_oovf   <= r_res_ovf;
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {{(16-STR_INDEX_W){1'b0}}, r_oidx};
    assign m_axis_tuser  = {r_oovf, r_oexist};

`ifndef SYNTHESIS
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("match and overflow flagged together");
    a_ovf_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))
        else $error("overflow result with nonzero index");
    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= MAXN_L)
        else $error("node count past capacity");
    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= SSD_L)
        else $error("write pointer past store depth");
    a_push_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_push)
        else $error("two node pushes for one name");
`endif

endmodule
